[design/rcba_pkg.sv]
// ----------------------------------------------------------------------------
// rcba_pkg
// Shared widths, operation and status codes and the table entry format for
// the reference-counted block allocator.
// ----------------------------------------------------------------------------
package rcba_pkg;

  localparam int NUM_BLOCKS_DEF = 65536;
  localparam int GROUP_SIZE_DEF = 512;

  localparam int OP_W    = 3;
  localparam int BLOCK_W = 16;
  localparam int COUNT_W = 16;
  localparam int VALUE_W = 17;
  localparam int LIMIT_W = 17;
  localparam int ST_W    = 3;

  localparam logic [LIMIT_W-1:0] LIMIT_RST = 17'h10000;

  localparam logic [OP_W-1:0] OP_ALLOC = 3'd0;
  localparam logic [OP_W-1:0] OP_GET   = 3'd1;
  localparam logic [OP_W-1:0] OP_SET   = 3'd2;
  localparam logic [OP_W-1:0] OP_ADD   = 3'd3;
  localparam logic [OP_W-1:0] OP_PUT   = 3'd4;

  localparam logic [ST_W-1:0] ST_OK      = 3'd0;
  localparam logic [ST_W-1:0] ST_FULL    = 3'd1;
  localparam logic [ST_W-1:0] ST_BADADDR = 3'd2;
  localparam logic [ST_W-1:0] ST_DOUBLE  = 3'd3;
  localparam logic [ST_W-1:0] ST_OVER    = 3'd4;

  // live: cnt is the reference count; free: cnt links to the next free block
  typedef struct packed {
    logic               mark;
    logic [COUNT_W-1:0] cnt;
  } entry_t;

endpackage

[design/refcounted_block_allocator.sv]
// ----------------------------------------------------------------------------
// refcounted_block_allocator
// Reference-counted block allocator; free list threaded through the count
// table, one read-modify-write of the table per request.
// ----------------------------------------------------------------------------
// Timing: the request and its table entry are registered on accept; the result
//   is registered in the execute cycle and strobed on out_strobe.
// One request at a time: busy stays high through the execute cycle, set by the single table
//   read-modify-write (read on accept, write back in the execute cycle).
// Reset: a clearing pass over all NUM_BLOCKS entries zeroes the table; busy is high
//   throughout. Configuration writes are taken at any time.
// The receiver cannot stall: each result is strobed for one cycle only.
module refcounted_block_allocator #(
  parameter int NUM_BLOCKS = rcba_pkg::NUM_BLOCKS_DEF,
  parameter int GROUP_SIZE = rcba_pkg::GROUP_SIZE_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [rcba_pkg::OP_W-1:0]           in_op,
  input  logic [rcba_pkg::BLOCK_W-1:0]        in_block,
  input  logic signed [rcba_pkg::VALUE_W-1:0] in_value,
  input  logic                                in_fake,
  output logic                                out_strobe,
  output logic [rcba_pkg::BLOCK_W-1:0]        out_alloc_block,
  output logic [rcba_pkg::COUNT_W-1:0]        out_ref_count,
  output logic [rcba_pkg::LIMIT_W-1:0]        out_free_total,
  output logic [rcba_pkg::ST_W-1:0]           out_status,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rcba_pkg::LIMIT_W-1:0]        cfg_limit_blocks
);

  localparam int AW  = $clog2(NUM_BLOCKS);
  localparam int BW  = rcba_pkg::BLOCK_W;
  localparam int CW  = rcba_pkg::COUNT_W;
  localparam int LW  = rcba_pkg::LIMIT_W;
  localparam int VW  = rcba_pkg::VALUE_W;
  localparam int GW  = $clog2(GROUP_SIZE);
  localparam int SH  = BW + GW;
  localparam int RW  = BW + 2;
  localparam longint RECIP = ((longint'(1) << SH) + GROUP_SIZE - 1) / GROUP_SIZE;
  localparam logic [RW-1:0] RECIP_V = RW'(RECIP);
  localparam logic [LW-1:0] NB_L    = LW'(NUM_BLOCKS);
  localparam logic [AW-1:0] CLR_LAST = AW'(NUM_BLOCKS - 1);
  localparam logic [GW:0]   GRP_WRAP = (GW+1)'(GROUP_SIZE);

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_EXEC} state_t;

  state_t state_r;

  logic [AW-1:0]        clr_r;
  logic [BW-1:0]        free_head_r,  free_head_nxt;
  logic [LW-1:0]        free_count_r, free_count_nxt;
  logic [LW-1:0]        end_block_r,  end_block_nxt;
  logic [GW-1:0]        end_grp_r,    end_grp_nxt;
  logic [LW-1:0]        limit_r;

  logic [rcba_pkg::OP_W-1:0] op_r;
  logic [BW-1:0]        blk_r;
  logic signed [VW-1:0] val_r;
  logic                 fake_r;
  logic [BW-1:0]        quo_r;
  logic [BW-1:0]        quo_nxt;
  logic [BW+RW-1:0]     prod;

  logic                 out_strobe_r;
  logic [BW-1:0]        out_alloc_r, out_alloc_nxt;
  logic [CW-1:0]        out_cnt_r,   out_cnt_nxt;
  logic [rcba_pkg::ST_W-1:0] out_st_r, out_st_nxt;

  logic                 accept;
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr, ram_raddr;
  rcba_pkg::entry_t     ram_wdata, ram_rdata;

  logic                 ex_we;
  logic [AW-1:0]        ex_waddr;
  rcba_pkg::entry_t     ex_wdata;

  logic [LW-1:0]        eff_lim;
  logic [BW-1:0]        rem;
  logic                 ref_blk;
  logic                 head_ok;
  logic                 skip;
  logic [LW-1:0]        a_end, a_nxt;
  logic [GW:0]          grp_inc;
  logic signed [VW:0]   sum;

  assign busy       = (state_r != S_IDLE);
  assign accept     = start && !busy;
  assign cfg_ready  = 1'b1;
  assign out_strobe      = out_strobe_r;
  assign out_alloc_block = out_alloc_r;
  assign out_ref_count   = out_cnt_r;
  assign out_free_total  = free_count_r;
  assign out_status      = out_st_r;

  // block / GROUP_SIZE by reciprocal, exact over the 16-bit range
  assign prod    = {{RW{1'b0}}, in_block} * {{BW{1'b0}}, RECIP_V};
  assign quo_nxt = BW'(prod >> SH);

  assign head_ok = (free_head_r != '0) && ({1'b0, free_head_r} < NB_L);

  always_comb begin
    ram_raddr = ((in_op == rcba_pkg::OP_ALLOC) ? free_head_r[AW-1:0] : in_block[AW-1:0]);
    if (state_r == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_r;
      ram_wdata = '0;
    end else begin
      ram_we    = ex_we && (state_r == S_EXEC);
      ram_waddr = ex_waddr;
      ram_wdata = ex_wdata;
    end
  end

  rcba_ram #(
    .WIDTH ($bits(rcba_pkg::entry_t)),
    .DEPTH (NUM_BLOCKS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // execute: modify the entry read on accept
  always_comb begin
    eff_lim = (limit_r < NB_L) ? limit_r : NB_L;
    rem     = blk_r - BW'(quo_r * GROUP_SIZE);
    ref_blk = (rem < BW'(2));
    skip    = (end_grp_r == '0);
    a_end   = end_block_r + (skip ? LW'(2) : LW'(0));
    a_nxt   = end_block_r + (skip ? LW'(3) : LW'(1));
    grp_inc = {1'b0, end_grp_r} + 1'b1;
    sum     = $signed({2'b00, ram_rdata.cnt}) + $signed({val_r[VW-1], val_r});

    free_head_nxt  = free_head_r;
    free_count_nxt = free_count_r;
    end_block_nxt  = end_block_r;
    end_grp_nxt    = end_grp_r;
    ex_we          = 1'b0;
    ex_waddr       = blk_r[AW-1:0];
    ex_wdata       = '0;
    out_alloc_nxt  = '0;
    out_cnt_nxt    = '0;
    out_st_nxt     = rcba_pkg::ST_OK;

    if (fake_r) begin
      // not counted
    end else if (op_r == rcba_pkg::OP_ALLOC) begin
      if (head_ok) begin
        free_head_nxt = ram_rdata.cnt;
        if (free_count_r != '0) begin
          free_count_nxt = free_count_r - 1'b1;
        end
        ex_we         = 1'b1;
        ex_waddr      = free_head_r[AW-1:0];
        ex_wdata.cnt  = CW'(1);
        out_alloc_nxt = free_head_r;
        out_cnt_nxt   = CW'(1);
      end else if (a_end >= eff_lim) begin
        out_st_nxt = rcba_pkg::ST_FULL;
      end else begin
        end_block_nxt = a_nxt;
        end_grp_nxt   = skip ? GW'(3) : ((grp_inc == GRP_WRAP) ? '0 : grp_inc[GW-1:0]);
        ex_we         = 1'b1;
        ex_waddr      = a_end[AW-1:0];
        ex_wdata.cnt  = CW'(1);
        out_alloc_nxt = a_end[BW-1:0];
        out_cnt_nxt   = CW'(1);
      end
    end else if (op_r > rcba_pkg::OP_PUT || blk_r == '0) begin
      // unknown op or no block
    end else if ({1'b0, blk_r} >= eff_lim || ref_blk) begin
      out_st_nxt = rcba_pkg::ST_BADADDR;
    end else if (ram_rdata.mark) begin
      unique case (op_r)
        rcba_pkg::OP_SET, rcba_pkg::OP_ADD: out_st_nxt = rcba_pkg::ST_BADADDR;
        rcba_pkg::OP_PUT:                   out_st_nxt = rcba_pkg::ST_DOUBLE;
        default:                            out_st_nxt = rcba_pkg::ST_OK;
      endcase
    end else begin
      out_cnt_nxt = ram_rdata.cnt;
      unique case (op_r)
        rcba_pkg::OP_SET: begin
          if (val_r < 0) begin
            out_st_nxt = rcba_pkg::ST_OVER;
          end else begin
            if (val_r != '0) begin
              out_cnt_nxt = val_r[CW-1:0];
            end
            ex_we        = 1'b1;
            ex_wdata.cnt = out_cnt_nxt;
          end
        end
        rcba_pkg::OP_ADD: begin
          if (sum[VW] || sum[VW-1]) begin
            out_st_nxt = rcba_pkg::ST_OVER;
          end else begin
            out_cnt_nxt  = sum[CW-1:0];
            ex_we        = 1'b1;
            ex_wdata.cnt = out_cnt_nxt;
          end
        end
        rcba_pkg::OP_PUT: begin
          if (ram_rdata.cnt == '0) begin
            out_st_nxt = rcba_pkg::ST_OVER;
          end else begin
            out_cnt_nxt = ram_rdata.cnt - 1'b1;
            ex_we       = 1'b1;
            if (out_cnt_nxt == '0) begin
              // last reference gone: push on the free list
              ex_wdata.mark  = 1'b1;
              ex_wdata.cnt   = free_head_r;
              free_head_nxt  = blk_r;
              free_count_nxt = free_count_r + 1'b1;
            end else begin
              ex_wdata.cnt = out_cnt_nxt;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_r        <= '0;
      free_head_r  <= '0;
      free_count_r <= '0;
      end_block_r  <= '0;
      end_grp_r    <= '0;
      limit_r      <= rcba_pkg::LIMIT_RST;
      out_strobe_r <= 1'b0;
      out_alloc_r  <= '0;
      out_cnt_r    <= '0;
      out_st_r     <= rcba_pkg::ST_OK;
    end else begin
      out_strobe_r <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        limit_r <= cfg_limit_blocks;
      end
      unique case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == CLR_LAST) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          state_r      <= S_IDLE;
          free_head_r  <= free_head_nxt;
          free_count_r <= free_count_nxt;
          end_block_r  <= end_block_nxt;
          end_grp_r    <= end_grp_nxt;
          out_strobe_r <= 1'b1;
          out_alloc_r  <= out_alloc_nxt;
          out_cnt_r    <= out_cnt_nxt;
          out_st_r     <= out_st_nxt;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= in_op;
      blk_r  <= in_block;
      val_r  <= in_value;
      fake_r <= in_fake;
      quo_r  <= quo_nxt;
    end
  end

  a_strobe_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r |-> $past(state_r == S_EXEC))
    else $error("result strobe without an execute cycle");

  a_table_write_src: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_CLEAR || state_r == S_EXEC))
    else $error("table written outside clear or execute");

  a_alloc_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe_r && out_alloc_r != '0) |->
      (out_st_r == rcba_pkg::ST_OK && out_cnt_r == CW'(1)))
    else $error("allocated block without count one");

  a_clear_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> (busy && !out_strobe_r))
    else $error("request window open during clearing pass");

endmodule

[design/rcba_ram.sv]
// ----------------------------------------------------------------------------
// rcba_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module rcba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[bench/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the reference-counted block allocator. A scoreboard
// keeps its own copy of the count table, free marks, free list and end
// pointer, predicts each result on request acceptance and checks each
// strobed result in order. Directed requests cover the corner cases, then
// random phases run under several limits and idling patterns.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int NB = rcba_pkg::NUM_BLOCKS_DEF;
  localparam int GS = rcba_pkg::GROUP_SIZE_DEF;
  localparam logic [rcba_pkg::OP_W-1:0] OP_FIRST_UNUSED = rcba_pkg::OP_PUT + 3'd1;
  localparam logic [rcba_pkg::OP_W-1:0] OP_LAST_UNUSED  = {rcba_pkg::OP_W{1'b1}};

  typedef struct {
    logic [rcba_pkg::BLOCK_W-1:0] alloc_block;
    logic [rcba_pkg::COUNT_W-1:0] ref_count;
    logic [rcba_pkg::LIMIT_W-1:0] free_total;
    logic [rcba_pkg::ST_W-1:0]    status;
  } alloc_result_t;

  class alloc_scoreboard;
    logic [rcba_pkg::COUNT_W-1:0] count_mem [NB];
    bit                           freed [NB];
    int                           head;
    int                           nfree;
    int                           end_ptr;
    int                           limit_reg;
    int                           errors;
    alloc_result_t                due [$];

    function new();
      foreach (count_mem[i]) begin
        count_mem[i] = '0;
        freed[i] = 1'b0;
      end
      head = 0;
      nfree = 0;
      end_ptr = 0;
      limit_reg = int'(rcba_pkg::LIMIT_RST);
      errors = 0;
    endfunction

    function void set_limit(logic [rcba_pkg::LIMIT_W-1:0] v);
      limit_reg = int'(v);
    endfunction

    function int pending();
      return due.size();
    endfunction

    function void note_request(logic [rcba_pkg::OP_W-1:0] op,
                               logic [rcba_pkg::BLOCK_W-1:0] blk,
                               logic signed [rcba_pkg::VALUE_W-1:0] val, logic fake);
      alloc_result_t r;
      int eff;
      int a;
      int nxt;
      int rc;
      int n;
      int b;
      bit got;
      r.alloc_block = '0;
      r.ref_count = '0;
      r.status = rcba_pkg::ST_OK;
      eff = (limit_reg < NB) ? limit_reg : NB;
      b = int'(blk);
      rc = 0;
      if (fake || op > rcba_pkg::OP_PUT) begin
      end else if (op == rcba_pkg::OP_ALLOC) begin
        got = 1'b0;
        if (head != 0) begin
          a = head;
          head = int'(count_mem[a]);
          if (nfree > 0) nfree--;
          got = 1'b1;
        end else begin
          a = end_ptr;
          if (a < eff) begin
            nxt = a + 1;
            if (a % GS == 0) begin
              a += 2;
              nxt += 2;
            end
            if (a < eff) begin
              end_ptr = nxt;
              got = 1'b1;
            end
          end
        end
        if (got) begin
          rc = 1;
          count_mem[a] = rc[rcba_pkg::COUNT_W-1:0];
          freed[a] = 1'b0;
          r.alloc_block = a[rcba_pkg::BLOCK_W-1:0];
        end else begin
          r.status = rcba_pkg::ST_FULL;
        end
      end else if (b == 0) begin
      end else if (b >= eff || b % GS < 2) begin
        r.status = rcba_pkg::ST_BADADDR;
      end else if (freed[b]) begin
        if (op == rcba_pkg::OP_SET || op == rcba_pkg::OP_ADD) r.status = rcba_pkg::ST_BADADDR;
        else if (op == rcba_pkg::OP_PUT) r.status = rcba_pkg::ST_DOUBLE;
      end else begin
        rc = int'(count_mem[b]);
        case (op)
          rcba_pkg::OP_SET: begin
            if (val < 0) r.status = rcba_pkg::ST_OVER;
            else if (val != 0) rc = int'(val);
          end
          rcba_pkg::OP_ADD: begin
            n = rc + int'(val);
            if (n < 0 || n > 65535) r.status = rcba_pkg::ST_OVER;
            else rc = n;
          end
          rcba_pkg::OP_PUT: begin
            if (rc == 0) begin
              r.status = rcba_pkg::ST_OVER;
            end else begin
              rc--;
              if (rc == 0) begin
                count_mem[b] = head[rcba_pkg::COUNT_W-1:0];
                head = b;
                freed[b] = 1'b1;
                nfree++;
              end
            end
          end
          default: begin
          end
        endcase
        if (r.status == rcba_pkg::ST_OK && !freed[b])
          count_mem[b] = rc[rcba_pkg::COUNT_W-1:0];
      end
      r.ref_count = rc[rcba_pkg::COUNT_W-1:0];
      r.free_total = nfree[rcba_pkg::LIMIT_W-1:0];
      due.push_back(r);
    endfunction

    task report_mismatch(string field, int got, int want);
      $display("mismatch at %0t: %s got %0d want %0d", $realtime, field, got, want);
      errors++;
    endtask

    task check_result(logic [rcba_pkg::BLOCK_W-1:0] ab, logic [rcba_pkg::COUNT_W-1:0] rc,
                      logic [rcba_pkg::LIMIT_W-1:0] ft, logic [rcba_pkg::ST_W-1:0] st);
      alloc_result_t w;
      if (due.size() == 0) begin
        report_mismatch("unrequested result, status", int'(st), -1);
      end else begin
        w = due.pop_front();
        if (ab !== w.alloc_block) report_mismatch("alloc_block", int'(ab), int'(w.alloc_block));
        if (rc !== w.ref_count) report_mismatch("ref_count", int'(rc), int'(w.ref_count));
        if (ft !== w.free_total) report_mismatch("free_total", int'(ft), int'(w.free_total));
        if (st !== w.status) report_mismatch("status", int'(st), int'(w.status));
      end
    endtask
  endclass

  logic                                clk;
  logic                                rst_n;
  logic                                start;
  logic                                busy;
  logic [rcba_pkg::OP_W-1:0]           in_op;
  logic [rcba_pkg::BLOCK_W-1:0]        in_block;
  logic signed [rcba_pkg::VALUE_W-1:0] in_value;
  logic                                in_fake;
  logic                                out_strobe;
  logic [rcba_pkg::BLOCK_W-1:0]        out_alloc_block;
  logic [rcba_pkg::COUNT_W-1:0]        out_ref_count;
  logic [rcba_pkg::LIMIT_W-1:0]        out_free_total;
  logic [rcba_pkg::ST_W-1:0]           out_status;
  logic                                cfg_valid;
  logic                                cfg_ready;
  logic [rcba_pkg::LIMIT_W-1:0]        cfg_limit_blocks;

  alloc_scoreboard sb;
  int gap_pct;

  refcounted_block_allocator DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_op            (in_op),
    .in_block         (in_block),
    .in_value         (in_value),
    .in_fake          (in_fake),
    .out_strobe       (out_strobe),
    .out_alloc_block  (out_alloc_block),
    .out_ref_count    (out_ref_count),
    .out_free_total   (out_free_total),
    .out_status       (out_status),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_limit_blocks (cfg_limit_blocks)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_strobe)
        sb.check_result(out_alloc_block, out_ref_count, out_free_total, out_status);
      if (start && !busy) sb.note_request(in_op, in_block, in_value, in_fake);
      if (cfg_valid && cfg_ready) sb.set_limit(cfg_limit_blocks);
    end
  end

  // one request; start stays high on return so back-to-back requests follow
  task do_req(input logic [rcba_pkg::OP_W-1:0] op, input int blk, input int val,
              input logic fake);
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start    <= 1'b1;
    in_op    <= op;
    in_block <= blk[rcba_pkg::BLOCK_W-1:0];
    in_value <= val[rcba_pkg::VALUE_W-1:0];
    in_fake  <= fake;
    do @(posedge clk); while (busy);
  endtask

  task settle();
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task write_limit(input int v);
    cfg_valid        <= 1'b1;
    cfg_limit_blocks <= v[rcba_pkg::LIMIT_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task rand_req(input int window);
    logic [rcba_pkg::OP_W-1:0] op;
    int s;
    int u;
    int blk;
    int val;
    s = $urandom_range(99);
    if (s < 30) op = rcba_pkg::OP_ALLOC;
    else if (s < 45) op = rcba_pkg::OP_GET;
    else if (s < 60) op = rcba_pkg::OP_SET;
    else if (s < 75) op = rcba_pkg::OP_ADD;
    else if (s < 95) op = rcba_pkg::OP_PUT;
    else begin
      u = $urandom_range(OP_FIRST_UNUSED, OP_LAST_UNUSED);
      op = u[rcba_pkg::OP_W-1:0];
    end
    s = $urandom_range(99);
    if (s < 80) blk = $urandom_range(2, window);
    else if (s < 86) blk = 0;
    else if (s < 92) blk = $urandom_range(0, NB / GS - 1) * GS + $urandom_range(0, 1);
    else blk = $urandom;
    s = $urandom_range(99);
    if (op == rcba_pkg::OP_SET) begin
      if (s < 60) val = $urandom_range(1, 4);
      else if (s < 70) val = 0;
      else if (s < 80) val = -$urandom_range(1, 32768);
      else val = $urandom_range(0, 65535);
    end else if (op == rcba_pkg::OP_ADD) begin
      if (s < 70) val = $urandom_range(0, 4) - 2;
      else if (s < 85) val = $urandom_range(0, 65535);
      else val = -$urandom_range(1, 32768);
    end else begin
      val = $urandom;
    end
    do_req(op, blk, val, $urandom_range(99) < 5);
  endtask

  task rand_phase(input int limit, input int pct, input int count, input int window);
    write_limit(limit);
    gap_pct = pct;
    repeat (count) rand_req(window);
    settle();
  endtask

  initial begin
    sb = new();
    gap_pct = 0;
    rst_n            <= 1'b0;
    start            <= 1'b0;
    in_op            <= rcba_pkg::OP_ALLOC;
    in_block         <= '0;
    in_value         <= '0;
    in_fake          <= 1'b0;
    cfg_valid        <= 1'b0;
    cfg_limit_blocks <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // no usable blocks at all
    write_limit(0);
    do_req(rcba_pkg::OP_ALLOC, 0, 0, 1'b0);
    do_req(rcba_pkg::OP_GET, 3, 0, 1'b0);
    do_req(rcba_pkg::OP_GET, 0, 0, 1'b0);
    settle();

    write_limit({rcba_pkg::LIMIT_W{1'b1}});
    do_req(rcba_pkg::OP_ALLOC, 0, 0, 1'b0);
    do_req(rcba_pkg::OP_ALLOC, 0, 0, 1'b0);
    do_req(rcba_pkg::OP_GET, 2, 0, 1'b0);
    do_req(rcba_pkg::OP_SET, 2, 65535, 1'b0);
    do_req(rcba_pkg::OP_ADD, 2, 1, 1'b0);
    do_req(rcba_pkg::OP_ADD, 2, -32768, 1'b0);
    do_req(rcba_pkg::OP_SET, 2, -1, 1'b0);
    do_req(rcba_pkg::OP_SET, 2, 0, 1'b0);
    do_req(rcba_pkg::OP_ADD, 2, 0, 1'b0);
    do_req(rcba_pkg::OP_SET, 2, 1, 1'b0);
    do_req(rcba_pkg::OP_PUT, 2, 0, 1'b0);
    do_req(rcba_pkg::OP_GET, 2, 0, 1'b0);
    do_req(rcba_pkg::OP_SET, 2, 5, 1'b0);
    do_req(rcba_pkg::OP_ADD, 2, 3, 1'b0);
    do_req(rcba_pkg::OP_PUT, 2, 0, 1'b0);
    do_req(rcba_pkg::OP_ADD, 3, -1, 1'b0);
    do_req(rcba_pkg::OP_PUT, 3, 0, 1'b0);
    do_req(rcba_pkg::OP_GET, GS, 0, 1'b0);
    do_req(rcba_pkg::OP_GET, GS + 1, 0, 1'b0);
    do_req(rcba_pkg::OP_SET, 65535, 7, 1'b0);
    do_req(rcba_pkg::OP_ALLOC, 0, 0, 1'b1);
    do_req(OP_FIRST_UNUSED, 2, 1, 1'b0);
    do_req(OP_LAST_UNUSED, 65535, -1, 1'b0);
    do_req(rcba_pkg::OP_ALLOC, 0, 0, 1'b0);
    do_req(rcba_pkg::OP_PUT, 2, 0, 1'b1);
    settle();

    rand_phase(int'(rcba_pkg::LIMIT_RST), 0, 120, 40);
    rand_phase(300, 77, 120, 60);
    rand_phase(60, 32, 120, 70);
    rand_phase(100000, 32, 110, 600);

    if (sb.errors == 0 && sb.pending() == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  initial begin
    #6000000;
    $display("status: fail");
    $finish;
  end

endmodule
